FILE: src/plq_pkg.sv
// shared types, codes and the sequencer microcode for the price level order queue
package plq_pkg;

    localparam int DEFAULT_SLOTS = 256;
    localparam int SLOT_W        = 8;
    localparam int ID_W          = 32;
    localparam int PRICE_W       = 32;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_POP    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_PRICE      = 3'd1,
        ST_NOT_LINKED = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_LINKED     = 3'd4
    } t_status;

    typedef struct packed {
        t_mode               mode;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     client_tag;
        logic [PRICE_W-1:0]  order_price;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot_out;
        logic [ID_W-1:0]     client_tag_out;
        logic                queue_live;
    } t_result;

    // microcode addresses
    typedef enum logic [1:0] {
        STEP_FETCH  = 2'd0,
        STEP_APPEND = 2'd1,
        STEP_UNLINK = 2'd2,
        STEP_REPORT = 2'd3
    } t_step;

    typedef struct packed {
        logic  take_in;      // wait for a transaction, then dispatch
        logic  emit;         // wait for a free result register, then load it
        logic  do_link;      // hook the new slot behind the tail
        logic  do_unlink;    // splice the addressed slot out
        logic  id_from_mem;  // result id from the id table, else from the transaction
        t_step nxt;
    } t_uword;

    function automatic t_uword uc_rom(t_step addr);
        t_uword w;
        w = '{take_in: 1'b0, emit: 1'b0, do_link: 1'b0, do_unlink: 1'b0,
              id_from_mem: 1'b0, nxt: STEP_FETCH};
        unique case (addr)
            STEP_FETCH: begin
                w.take_in = 1'b1;
            end
            STEP_APPEND: begin
                w.emit    = 1'b1;
                w.do_link = 1'b1;
            end
            STEP_UNLINK: begin
                w.emit        = 1'b1;
                w.do_unlink   = 1'b1;
                w.id_from_mem = 1'b1;
            end
            STEP_REPORT: begin
                w.emit        = 1'b1;
                w.id_from_mem = 1'b1;
            end
            default: begin
                w.take_in = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: src/price_level_order_queue.sv
// price level order queue: microcoded doubly linked list over a slot table
//
// Time-priority queue of orders at one price level. Each input transaction
// appends a slot at the tail, cancels any linked slot, peeks at the head or
// pops the head, and yields exactly one result transaction. The list lives in
// three single-port-write tables (next link, prev link, order id) of
// min(SLOTS, 256) entries with registered reads, plus one linked bit per
// entry that reset clears, so the block is usable right after reset. A
// two-step microprogram runs each transaction: the fetch step checks the
// request and reads the addressed slot's links and id (and writes the new
// slot's entries on append), the second step relinks the neighbors and loads
// the result register. The next item is taken only after the second step,
// set by the one read and the following write on the link tables; a result
// left in the output register stalls that step only while not yet taken.
// level_price is written through its own channel, ready whenever out of
// reset; the user writes it only while idle, not enforced by the block.
module price_level_order_queue
    import plq_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_item               i_in_data,

    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_result             o_out_data,

    // level price register
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [PRICE_W-1:0]  i_cfg_data
);

    // only slots an 8-bit handle can name ever get storage
    localparam int DEPTH  = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int LINK_W = IDX_W + 1;
    // a link with its top bit set is the null marker
    localparam logic [LINK_W-1:0] NULL_LINK = {1'b1, {IDX_W{1'b0}}};

    // config
    logic [PRICE_W-1:0] r_level_price;

    // sequencer
    t_step  r_step, n_step;
    t_uword uw;

    // list state
    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_tail, n_tail;
    logic [DEPTH-1:0]  r_linked;

    // slot tables
    logic [LINK_W-1:0] nxt_mem [DEPTH];
    logic [LINK_W-1:0] prv_mem [DEPTH];
    logic [ID_W-1:0]   id_mem  [DEPTH];
    logic [LINK_W-1:0] r_nxt_rd, r_prv_rd;
    logic [ID_W-1:0]   r_id_rd;

    // per-transaction registers
    t_status           r_status;
    logic [SLOT_W-1:0] r_sout;
    logic [ID_W-1:0]   r_oid;
    logic [IDX_W-1:0]  r_addr;

    // result register
    logic    r_out_valid;
    t_result r_out;

    // fetch-step decode
    logic              accept;
    logic              fire;
    logic              out_free;
    logic              in_range;
    logic [IDX_W-1:0]  slot_idx;
    logic [IDX_W-1:0]  in_addr;
    logic              slot_linked;
    t_status           in_status;
    logic [SLOT_W-1:0] in_sout;
    logic              app_wr;
    t_step             disp_step;

    // table write ports
    logic              nxt_we, prv_we, id_we;
    logic [IDX_W-1:0]  nxt_wa, prv_wa;
    logic [LINK_W-1:0] nxt_wd, prv_wd;

    logic [ID_W-1:0]   res_id;

    // no transaction is taken while reset is held
    assign uw          = uc_rom(r_step);
    assign o_in_ready  = uw.take_in && i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign out_free    = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign fire        = uw.emit && out_free;

    // request check on the incoming transaction
    assign slot_idx    = IDX_W'(i_in_data.slot);
    assign in_range    = (32'(i_in_data.slot) < 32'(SLOTS));
    assign slot_linked = in_range && r_linked[slot_idx];

    always_comb begin
        in_status = ST_OK;
        in_sout   = i_in_data.slot;
        in_addr   = slot_idx;
        disp_step = STEP_REPORT;
        unique case (i_in_data.mode)
            MODE_APPEND: begin
                if (i_in_data.order_price != r_level_price) begin
                    in_status = ST_PRICE;
                end else if (!in_range) begin
                    in_status = ST_NOT_LINKED;
                end else if (slot_linked) begin
                    in_status = ST_LINKED;
                end else begin
                    disp_step = STEP_APPEND;
                end
            end
            MODE_CANCEL: begin
                if (!slot_linked) begin
                    in_status = ST_NOT_LINKED;
                end else begin
                    disp_step = STEP_UNLINK;
                end
            end
            MODE_PEEK, MODE_POP: begin
                in_addr = r_head[IDX_W-1:0];
                if (r_head[IDX_W]) begin
                    in_status = ST_EMPTY;
                    in_sout   = '0;
                end else begin
                    in_sout = SLOT_W'(r_head[IDX_W-1:0]);
                    if (i_in_data.mode == MODE_POP) begin
                        disp_step = STEP_UNLINK;
                    end
                end
            end
            default: begin
                in_status = ST_OK;
            end
        endcase
    end

    // append writes the new slot's entries during fetch
    assign app_wr = accept && (disp_step == STEP_APPEND);

    // step counter with conditional jumps
    always_comb begin
        n_step = r_step;
        if (uw.take_in) begin
            if (accept) begin
                n_step = disp_step;
            end
        end else if (fire) begin
            n_step = uw.nxt;
        end
    end

    // relinking and table write ports
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        nxt_we = app_wr;
        prv_we = app_wr;
        id_we  = app_wr;
        nxt_wa = in_addr;
        nxt_wd = NULL_LINK;
        prv_wa = in_addr;
        prv_wd = r_tail;
        if (fire && uw.do_link) begin
            if (!r_tail[IDX_W]) begin
                nxt_we = 1'b1;
                nxt_wa = r_tail[IDX_W-1:0];
                nxt_wd = {1'b0, r_addr};
            end else begin
                n_head = {1'b0, r_addr};
            end
            n_tail = {1'b0, r_addr};
        end
        if (fire && uw.do_unlink) begin
            // predecessor now points past the removed slot
            if (!r_prv_rd[IDX_W]) begin
                nxt_we = 1'b1;
                nxt_wa = r_prv_rd[IDX_W-1:0];
                nxt_wd = r_nxt_rd;
            end else begin
                n_head = r_nxt_rd;
            end
            // successor points back past it
            if (!r_nxt_rd[IDX_W]) begin
                prv_we = 1'b1;
                prv_wa = r_nxt_rd[IDX_W-1:0];
                prv_wd = r_prv_rd;
            end else begin
                n_tail = r_prv_rd;
            end
        end
    end

    // id is only reported for successful operations
    always_comb begin
        res_id = uw.id_from_mem ? r_id_rd : r_oid;
        if (r_status != ST_OK) begin
            res_id = '0;
        end
    end

    // slot tables, read data registered
    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (accept) begin
            r_nxt_rd <= nxt_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (prv_we) begin
            prv_mem[prv_wa] <= prv_wd;
        end
        if (accept) begin
            r_prv_rd <= prv_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            id_mem[in_addr] <= i_in_data.client_tag;
        end
        if (accept) begin
            r_id_rd <= id_mem[in_addr];
        end
    end

    // transaction payload captured at fetch
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= in_status;
            r_sout   <= in_sout;
            r_oid    <= i_in_data.client_tag;
            r_addr   <= in_addr;
        end
        if (fire) begin
            r_out.status         <= r_status;
            r_out.slot_out       <= r_sout;
            r_out.client_tag_out <= res_id;
            r_out.queue_live     <= !n_head[IDX_W];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= STEP_FETCH;
            r_head        <= NULL_LINK;
            r_tail        <= NULL_LINK;
            r_linked      <= '0;
            r_out_valid   <= 1'b0;
            r_level_price <= '0;
        end else begin
            r_step <= n_step;
            r_head <= n_head;
            r_tail <= n_tail;
            if (fire && uw.do_link) begin
                r_linked[r_addr] <= 1'b1;
            end
            if (fire && uw.do_unlink) begin
                r_linked[r_addr] <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_level_price <= i_cfg_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // head and tail are null together
    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head[IDX_W] == r_tail[IDX_W])
        else $error("head and tail disagree on emptiness");

    // the list is empty exactly when no slot is linked
    a_empty_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_linked == '0) == r_head[IDX_W])
        else $error("linked bits disagree with head");

    // head and tail always name linked slots
    a_head_linked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_head[IDX_W] |-> r_linked[r_head[IDX_W-1:0]])
        else $error("head names an unlinked slot");

    a_tail_linked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tail[IDX_W] |-> r_linked[r_tail[IDX_W-1:0]])
        else $error("tail names an unlinked slot");

    // an accepted request always moves on to a finishing step
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted request did not leave fetch");

endmodule
